/* design/fatlb_pkg.sv */
// Shared types and constants for the fully associative translation buffer.
package fatlb_pkg;

   // Field widths of the request and response payloads.
   localparam int ADDR_BITS        = 32;
   localparam int PAGE_SHIFT       = 12;
   localparam int PAGE_BITS        = 20;
   localparam int INDEX_FIELD_BITS = 6;

   // The match search resolves groups of at most eight entries per stage.
   localparam int GROUP_LIMIT_BITS = 3;

   // Victim selection uses a 16-bit Galois LFSR.
   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   // Request kinds; the fourth code is unused and leaves the state alone.
   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_FILL   = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic compare;
      logic encode;
      logic select;
      logic load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

/* design/fatlb_if.sv */
// Request and response channel interfaces of the translation buffer.
interface fatlb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] linear_address;
   logic [31:0] page_entry;

   modport source (output valid, output kind, output linear_address, output page_entry,
                   input ready);
   modport sink (input valid, input kind, input linear_address, input page_entry,
                 output ready);
endinterface

interface fatlb_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] frame_base;
   logic [5:0]  entry_index;

   modport source (output valid, output hit, output frame_base, output entry_index,
                   input ready);
   modport sink (input valid, input hit, input frame_base, input entry_index,
                 output ready);
endinterface

/* design/fully_associative_tlb.sv */
// Top level of the fully associative translation buffer.
//
//   Channel   Direction  Contents
//   req_chan  in         kind, linear_address, page_entry
//   rsp_chan  out        hit, frame_base, entry_index
//
// Each request passes through acceptance, a parallel tag compare, a grouped
// priority encode, the entry select with the frame RAM access, and the load of
// the output register; the match search has three stages. A new request is
// accepted while the previous response waits; a finished request holds until
// the output register frees. Reset clears all valid bits and seeds the victim
// LFSR; no clearing pass follows.
module fully_associative_tlb import fatlb_pkg::*; #(
   parameter int INDEX_BITS = 6
) (
   input logic        clock,
   input logic        reset,
   fatlb_req_if.sink  req_chan,
   fatlb_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller.
   fatlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   fatlb_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_chan.kind),
      .req_linear_address (req_chan.linear_address),
      .req_page_entry     (req_chan.page_entry),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_hit            (rsp_chan.hit),
      .rsp_frame_base     (rsp_chan.frame_base),
      .rsp_entry_index    (rsp_chan.entry_index)
   );

endmodule

/* design/fatlb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fatlb_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fatlb_ctrl.sv */
// Sequencing state machine of the translation buffer.
module fatlb_ctrl import fatlb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_ENC  = 5'b00100,
      ST_SEL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state: one step per search stage, then wait for room at the output.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CMP;
         ST_CMP:  state_in = ST_ENC;
         ST_ENC:  state_in = ST_SEL;
         ST_SEL:  state_in = ST_DONE;
         ST_DONE: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath commands decoded from the state.
   always_comb begin
      cmd.capture = accept;
      cmd.compare = (state_ff == ST_CMP);
      cmd.encode  = (state_ff == ST_ENC);
      cmd.select  = (state_ff == ST_SEL);
      cmd.load    = (state_ff == ST_DONE) && status.out_free;
   end

endmodule

/* design/fatlb_datapath.sv */
// Entry store, match search, victim LFSR and response register.
module fatlb_datapath import fatlb_pkg::*; #(
   parameter int INDEX_BITS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status,
   input  logic [1:0]                  req_kind,
   input  logic [ADDR_BITS-1:0]        req_linear_address,
   input  logic [ADDR_BITS-1:0]        req_page_entry,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [ADDR_BITS-1:0]        rsp_frame_base,
   output logic [INDEX_FIELD_BITS-1:0] rsp_entry_index
);

   localparam int ENTRIES    = 1 << INDEX_BITS;
   localparam int GROUP_BITS = (INDEX_BITS < GROUP_LIMIT_BITS) ? INDEX_BITS : GROUP_LIMIT_BITS;
   localparam int GROUP_SIZE = 1 << GROUP_BITS;
   localparam int GROUPS     = ENTRIES >> GROUP_BITS;
   localparam int GSEL_BITS  = (INDEX_BITS > GROUP_BITS) ? INDEX_BITS - GROUP_BITS : 1;

   // Captured request.
   kind_type             kind_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] pte_frame_ff;

   // Entry state: valid bits and page tags as compare cells, frames in RAM.
   logic [ENTRIES-1:0]   valid_ff;
   logic [PAGE_BITS-1:0] page_cell_ff [ENTRIES];
   logic [15:0]          lfsr_ff;
   logic [15:0]          lfsr_in;

   // Search pipeline.
   logic [ENTRIES-1:0]    match_ff;
   logic [ENTRIES-1:0]    match_in;
   logic [GROUPS-1:0]     grp_any_ff;
   logic [GROUPS-1:0]     grp_any_in;
   logic [GROUP_BITS-1:0] grp_off_ff [GROUPS];
   logic [GROUP_BITS-1:0] grp_off_in [GROUPS];
   logic                  sel_any;
   logic [GSEL_BITS-1:0]  sel_grp;
   logic [INDEX_BITS-1:0] sel_idx;
   logic [INDEX_BITS-1:0] target_idx;
   logic                  hit_any_ff;
   logic [INDEX_BITS-1:0] idx_ff;

   // Frame RAM.
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [PAGE_BITS-1:0] ram_rd_data;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic                        rsp_hit_in;
   logic [ADDR_BITS-1:0]        rsp_frame_ff;
   logic [ADDR_BITS-1:0]        rsp_frame_in;
   logic [INDEX_FIELD_BITS-1:0] rsp_index_ff;
   logic [INDEX_FIELD_BITS-1:0] rsp_index_in;

   // Capture the request fields at acceptance.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= kind_type'(req_kind);
         page_ff      <= req_linear_address[ADDR_BITS-1:PAGE_SHIFT];
         pte_frame_ff <= req_page_entry[ADDR_BITS-1:PAGE_SHIFT];
      end
   end

   // Compare the page number against every valid entry.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (page_cell_ff[i] == page_ff);
      end
   end

   // Lowest matching offset inside each group of entries.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = 1'b0;
         grp_off_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (match_ff[g * GROUP_SIZE + j]) begin
               grp_any_in[g] = 1'b1;
               grp_off_in[g] = GROUP_BITS'(j);
            end
         end
      end
   end

   // Lowest matching group, then the entry index and the fill target.
   always_comb begin
      sel_any = 1'b0;
      sel_grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            sel_any = 1'b1;
            sel_grp = GSEL_BITS'(g);
         end
      end
      sel_idx    = (INDEX_BITS'(sel_grp) << GROUP_BITS) | INDEX_BITS'(grp_off_ff[sel_grp]);
      target_idx = sel_any ? sel_idx : lfsr_ff[INDEX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (cmd.encode) begin
         grp_any_ff <= grp_any_in;
         grp_off_ff <= grp_off_in;
      end
      if (cmd.select) begin
         hit_any_ff <= sel_any;
         idx_ff     <= (kind_ff == KIND_FILL) ? target_idx : sel_idx;
      end
   end

   // Galois step of the victim LFSR.
   assign lfsr_in = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'h0000);

   // Entry updates: a fill writes one slot, a flush clears every valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         lfsr_ff  <= LFSR_SEED;
      end else if (cmd.select) begin
         if (kind_ff == KIND_FILL) begin
            valid_ff[target_idx] <= 1'b1;
            if (!sel_any) begin
               lfsr_ff <= lfsr_in;
            end
         end else if (kind_ff == KIND_FLUSH) begin
            valid_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select && (kind_ff == KIND_FILL)) begin
         page_cell_ff[target_idx] <= page_ff;
      end
   end

   assign ram_wr_en = cmd.select && (kind_ff == KIND_FILL);
   assign ram_rd_en = cmd.select && (kind_ff == KIND_LOOKUP);

   fatlb_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (ENTRIES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (target_idx),
      .wr_data (pte_frame_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (sel_idx),
      .rd_data (ram_rd_data)
   );

   // Response contents by request kind.
   always_comb begin
      rsp_hit_in   = 1'b0;
      rsp_frame_in = '0;
      rsp_index_in = '0;
      unique case (kind_ff)
         KIND_LOOKUP: begin
            if (hit_any_ff) begin
               rsp_hit_in   = 1'b1;
               rsp_frame_in = {ram_rd_data, {PAGE_SHIFT{1'b0}}};
               rsp_index_in = INDEX_FIELD_BITS'(idx_ff);
            end
         end
         KIND_FILL: begin
            rsp_hit_in   = 1'b1;
            rsp_frame_in = {pte_frame_ff, {PAGE_SHIFT{1'b0}}};
            rsp_index_in = INDEX_FIELD_BITS'(idx_ff);
         end
         default: begin
            rsp_hit_in = 1'b0;
         end
      endcase
   end

   // Output register: filled on load, emptied when the response is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_frame_ff <= rsp_frame_in;
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_base  = rsp_frame_ff;
   assign rsp_entry_index = rsp_index_ff;

   // A fill leaves its target entry valid.
   a_fill_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.select && (kind_ff == KIND_FILL) |=> valid_ff[idx_ff])
      else $error("fill did not mark its entry valid");

   // A flush empties the whole buffer.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.select && (kind_ff == KIND_FLUSH) |=> (valid_ff == '0))
      else $error("flush left valid entries");

   // A lookup hit always names an entry that matched in the compare stage.
   a_hit_matched: assert property (@(posedge clock) disable iff (reset)
      cmd.select && (kind_ff == KIND_LOOKUP) && sel_any |-> match_ff[sel_idx])
      else $error("selected entry did not match");

   // The LFSR never reaches the all-zero lockup state.
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 16'h0000)
      else $error("victim LFSR reached zero");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the fully associative translation buffer.
module tb import fatlb_pkg::*; ();

   localparam int          ENTRY_COUNT  = 64;
   localparam int          POOL_SIZE    = 80;
   localparam int          RANDOM_ITEMS = 1250;
   localparam int          IDLE_LIMIT   = 1000;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          REPORT_LIMIT = 10;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam logic [7:0]  STALL_PATTERN = 8'b1011_0010;

   typedef struct packed {
      logic        hit;
      logic [31:0] frame_base;
      logic [5:0]  entry_index;
   } translation_type;

   logic clock;
   logic reset;

   fatlb_req_if req_chan ();
   fatlb_rsp_if rsp_chan ();

   fully_associative_tlb #(.INDEX_BITS(6)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the translation entries and the victim LFSR, in their reset state.
   logic        entry_valid [ENTRY_COUNT] = '{default: 1'b0};
   logic [19:0] entry_page  [ENTRY_COUNT] = '{default: 20'h00000};
   logic [19:0] entry_frame [ENTRY_COUNT] = '{default: 20'h00000};
   logic [15:0] victim_lfsr = LFSR_SEED;

   translation_type expected_translations[$];
   int              mismatch_count;
   int              burst_left;
   int              idle_cycles;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the response to one request and updates the shadow entries.
   function automatic translation_type predict_translation(input logic [1:0]  kind,
                                                           input logic [31:0] addr,
                                                           input logic [31:0] pte);
      translation_type result;
      logic [19:0]     page;
      int              slot;
      int              i;
      bit              found;
      result = '0;
      page   = addr[31:12];
      slot   = 0;
      found  = 1'b0;
      // The lowest matching valid entry wins.
      for (i = 0; i < ENTRY_COUNT; i++) begin
         if (!found && entry_valid[i] && entry_page[i] == page) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (kind == KIND_LOOKUP) begin
         if (found) begin
            result.hit         = 1'b1;
            result.frame_base  = {entry_frame[slot], 12'h000};
            result.entry_index = slot[5:0];
         end
      end else if (kind == KIND_FILL) begin
         // A new page takes the victim slot and steps the LFSR; a known page
         // is overwritten in place.
         if (!found) begin
            slot        = int'(victim_lfsr[5:0]);
            victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS)
                                         : (victim_lfsr >> 1);
         end
         entry_valid[slot]  = 1'b1;
         entry_page[slot]   = page;
         entry_frame[slot]  = pte[31:12];
         result.hit         = 1'b1;
         result.frame_base  = {pte[31:12], 12'h000};
         result.entry_index = slot[5:0];
      end else if (kind == KIND_FLUSH) begin
         for (i = 0; i < ENTRY_COUNT; i++) entry_valid[i] = 1'b0;
      end
      return result;
   endfunction

   // Each accepted request queues its expected response.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_translations.push_back(predict_translation(req_chan.kind,
            req_chan.linear_address, req_chan.page_entry));
      end
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      translation_type wanted;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_translations.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected response: hit %b frame_base %h entry_index %0d",
                        rsp_chan.hit, rsp_chan.frame_base, rsp_chan.entry_index);
         end else begin
            wanted = expected_translations.pop_front();
            if (rsp_chan.hit !== wanted.hit || rsp_chan.frame_base !== wanted.frame_base ||
                rsp_chan.entry_index !== wanted.entry_index) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $write("Mismatch: expected hit %b frame_base %h entry_index %0d,",
                         wanted.hit, wanted.frame_base, wanted.entry_index);
                  $display(" got hit %b frame_base %h entry_index %0d",
                           rsp_chan.hit, rsp_chan.frame_base, rsp_chan.entry_index);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The response side stalls in stretches of changing character.
   initial begin : response_stall
      int mode;
      int span;
      int phase;
      rsp_chan.ready = 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_chan.ready <= 1'b1;
               end
               1: begin
                  rsp_chan.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_chan.ready <= STALL_PATTERN[phase % 8];
                  phase++;
               end
               default: begin
                  rsp_chan.ready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   // Sends one request in bursts separated by random gaps.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                               input logic [31:0] pte);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid          <= 1'b1;
      req_chan.kind           <= kind;
      req_chan.linear_address <= addr;
      req_chan.page_entry     <= pte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Lookups, a flush and the unused kind on an empty buffer.
   task automatic test_empty_buffer();
      send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_FLUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_UNUSED, 32'h0000_0000, 32'h0000_0000);
   endtask

   // Fills at the extreme pages, then hits and a neighboring miss.
   task automatic test_fill_and_hit();
      send_request(KIND_FILL,   32'h0000_0000, 32'hFFFF_FFFF);
      send_request(KIND_FILL,   32'hFFFF_FFFF, 32'h0000_0000);
      send_request(KIND_FILL,   32'h1234_5ABC, 32'hDEAD_BEEF);
      send_request(KIND_LOOKUP, 32'h0000_0FFF, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'hFFFF_F000, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, 32'h1234_5000, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'h1234_4ABC, 32'h0000_0000);
   endtask

   // A fill of a page already present rewrites that entry in place.
   task automatic test_refill_in_place();
      send_request(KIND_FILL,   32'h1234_5678, 32'hCAFE_F00D);
      send_request(KIND_LOOKUP, 32'h1234_5FFF, 32'h0000_0000);
      send_request(KIND_FILL,   32'h0000_0123, 32'h5A5A_5FFF);
      send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
   endtask

   // A flush makes every lookup miss until the next fill.
   task automatic test_flush();
      send_request(KIND_FLUSH,  32'h0000_0000, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'h1234_5000, 32'h0000_0000);
      send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(KIND_FILL,   32'hFFFF_FABC, 32'h8000_0FFF);
      send_request(KIND_LOOKUP, 32'hFFFF_F000, 32'h0000_0000);
   endtask

   // The unused kind must leave the entries alone.
   task automatic test_unused_kind();
      send_request(KIND_UNUSED, 32'hFFFF_F000, 32'hFFFF_FFFF);
      send_request(KIND_LOOKUP, 32'hFFFF_F123, 32'h0000_0000);
   endtask

   // Random traffic over a working set slightly larger than the buffer.
   task automatic test_random_traffic(input int count);
      logic [19:0] page_pool [POOL_SIZE];
      logic [19:0] page;
      logic [31:0] addr;
      int          pick;
      int          i;
      for (i = 0; i < POOL_SIZE; i++) page_pool[i] = 20'($urandom);
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
         addr = {page, 12'($urandom)};
         // Slowly drift the working set so old entries go stale.
         if ($urandom_range(0, 49) == 0)
            page_pool[$urandom_range(2, POOL_SIZE - 1)] = 20'($urandom);
         if (pick < 50) begin
            send_request(KIND_LOOKUP, addr, $urandom);
         end else if (pick < 58) begin
            // One page bit off from a known page.
            send_request(KIND_LOOKUP, addr ^ (32'h1000 << $urandom_range(0, 19)), $urandom);
         end else if (pick < 64) begin
            send_request(KIND_LOOKUP, $urandom, $urandom);
         end else if (pick < 95) begin
            send_request(KIND_FILL, addr, $urandom);
         end else if (pick < 97) begin
            send_request(KIND_FLUSH, $urandom, $urandom);
         end else begin
            send_request(KIND_UNUSED, addr, $urandom);
         end
      end
   endtask

   // Reset, the directed tests, random traffic and the final verdict.
   initial begin
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.kind           = KIND_LOOKUP;
      req_chan.linear_address = '0;
      req_chan.page_entry     = '0;
      burst_left              = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_buffer();
      test_fill_and_hit();
      test_refill_in_place();
      test_flush();
      test_unused_kind();
      test_random_traffic(RANDOM_ITEMS);
      req_chan.valid <= 1'b0;

      while (expected_translations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
